### hw/rtl/subset_sum_two_machine_split_core_defines.svh
// Assertion macros for the top-level core file, which checks its own logic.
`ifndef SUBSET_SUM_TWO_MACHINE_SPLIT_CORE_DEFINES_SVH
`define SUBSET_SUM_TWO_MACHINE_SPLIT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SSTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSTS_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define SSTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSTS_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

### hw/rtl/ssts_pkg.sv
`timescale 1ns / 1ps
package ssts_pkg;

	localparam int CAP_W = 12;
	localparam int START_W = 18;
	localparam logic [CAP_W-1:0] CAP_RESET = 12'd4095;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_SWEEP,
		TOP_LAUNCH,
		TOP_TRACE
	} top_state_t;

	typedef enum logic [2:0] {
		TR_IDLE,
		TR_RD,
		TR_EX,
		EM_RD,
		EM_OUT
	} trace_state_t;

endpackage

### hw/rtl/ssts_ram.sv
`timescale 1ns / 1ps
module ssts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

### hw/rtl/ssts_sweep.sv
`timescale 1ns / 1ps
module ssts_sweep import ssts_pkg::*; #(
	parameter int MAX_JOBS = 64,
	parameter int MAX_CAPACITY = 4096,
	parameter int LENGTH_BITS = 12,
	localparam int AW = $clog2(MAX_CAPACITY),
	localparam int KW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   first,
	input  logic [LENGTH_BITS-1:0] len,
	input  logic [KW-1:0]          item,
	output logic [AW-1:0]          take_raddr,
	input  logic [MAX_JOBS-1:0]    take_rdata,
	output logic                   take_we,
	output logic [AW-1:0]          take_waddr,
	output logic [MAX_JOBS-1:0]    take_wdata,
	output logic                   done
);

	localparam int DW = ((AW > LENGTH_BITS) ? AW : LENGTH_BITS) + 1;

	logic                   busy_q;
	logic [AW-1:0]          j_q;
	logic                   first_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [KW-1:0]          item_q;
	logic                   v_s1;
	logic [AW-1:0]          j_s1;
	logic                   ge_s1;

	logic [DW-1:0]       diff;
	logic [AW-1:0]       lo_addr;
	logic [AW-1:0]       row_a_rd;
	logic [AW-1:0]       row_b_rd;
	logic [AW-1:0]       old_row;
	logic [AW-1:0]       base_row;
	logic [DW-1:0]       cand;
	logic                raise;
	logic [AW-1:0]       new_row;
	logic [MAX_JOBS-1:0] item_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			v_s1 <= 1'b0;
			j_q <= '0;
		end else begin
			v_s1 <= busy_q;
			if (start) begin
				busy_q <= 1'b1;
				j_q <= AW'(MAX_CAPACITY - 1);
			end else if (busy_q) begin
				if (j_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					j_q <= j_q - AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			first_q <= first;
			len_q <= len;
			item_q <= item;
		end
		j_s1 <= j_q;
		ge_s1 <= DW'(j_q) >= DW'(len_q);
	end

	assign diff = DW'(j_q) - DW'(len_q);
	assign lo_addr = diff[AW-1:0];

	// Two copies of the row, written alike, give the two reads of each budget step.
	ssts_ram #(.WIDTH(AW), .DEPTH(MAX_CAPACITY)) u_row_a (
		.clk(clk), .we(v_s1), .waddr(j_s1), .wdata(new_row),
		.raddr(j_q), .rdata_q(row_a_rd)
	);

	ssts_ram #(.WIDTH(AW), .DEPTH(MAX_CAPACITY)) u_row_b (
		.clk(clk), .we(v_s1), .waddr(j_s1), .wdata(new_row),
		.raddr(lo_addr), .rdata_q(row_b_rd)
	);

	// The first job of a set sees an all-zero row whatever the memory holds.
	always_comb begin
		old_row = first_q ? '0 : row_a_rd;
		base_row = first_q ? '0 : row_b_rd;
		cand = DW'(base_row) + DW'(len_q);
		raise = ge_s1 && (cand > DW'(old_row));
		new_row = raise ? cand[AW-1:0] : old_row;
		item_mask = MAX_JOBS'(1) << item_q;
	end

	assign take_raddr = j_q;
	assign take_we = v_s1;
	assign take_waddr = j_s1;
	assign take_wdata = (take_rdata & ~item_mask) | (raise ? item_mask : '0);
	assign done = v_s1 && (j_s1 == '0);

endmodule

### hw/rtl/ssts_trace.sv
`timescale 1ns / 1ps
module ssts_trace import ssts_pkg::*; #(
	parameter int MAX_JOBS = 64,
	parameter int MAX_CAPACITY = 4096,
	parameter int LENGTH_BITS = 12,
	localparam int AW = $clog2(MAX_CAPACITY),
	localparam int KW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1,
	localparam int CNTW = $clog2(MAX_JOBS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [CNTW-1:0]        n,
	input  logic [CAP_W-1:0]       cap,
	output logic [AW-1:0]          take_raddr,
	input  logic [MAX_JOBS-1:0]    take_rdata,
	output logic [KW-1:0]          store_raddr,
	input  logic [LENGTH_BITS-1:0] store_rdata,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [START_W-1:0]     start_time,
	output logic                   on_first_machine,
	output logic                   last_result,
	output logic                   done
);

	localparam int DW = ((AW > LENGTH_BITS) ? AW : LENGTH_BITS) + 1;
	localparam int CMPW = ((AW > CAP_W) ? AW : CAP_W) + 1;

	trace_state_t state_q, state_d;

	logic [CNTW-1:0]     n_q;
	logic [KW-1:0]       k_q;
	logic [KW-1:0]       i_q;
	logic [AW-1:0]       w_q;
	logic [MAX_JOBS-1:0] chosen_q;
	logic [START_W-1:0]  first_q;
	logic [START_W-1:0]  second_q;
	logic                out_valid_q;
	logic [START_W-1:0]  start_time_q;
	logic                on_first_q;
	logic                last_q;

	logic          load;
	logic          is_last;
	logic          take_bit;
	logic [AW-1:0] w_start;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TR_IDLE: if (start) state_d = TR_RD;
			TR_RD: state_d = TR_EX;
			TR_EX: state_d = (k_q == '0) ? EM_RD : TR_RD;
			EM_RD: state_d = EM_OUT;
			EM_OUT: if (load) state_d = is_last ? TR_IDLE : EM_RD;
			default: state_d = TR_IDLE;
		endcase
	end

	always_comb begin
		load = (state_q == EM_OUT) && (!out_valid_q || !out_stall);
		is_last = i_q == KW'(n_q - CNTW'(1));
		done = load && is_last;
		take_bit = take_rdata[k_q];
		take_raddr = w_q;
		store_raddr = ((state_q == EM_RD) || (state_q == EM_OUT)) ? i_q : k_q;
		if (CMPW'(cap) > CMPW'(MAX_CAPACITY - 1)) begin
			w_start = AW'(MAX_CAPACITY - 1);
		end else begin
			w_start = AW'(cap);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TR_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == TR_IDLE)) begin
			n_q <= n;
			k_q <= KW'(n - CNTW'(1));
			w_q <= w_start;
			first_q <= '0;
			second_q <= '0;
		end
		if (state_q == TR_EX) begin
			chosen_q[k_q] <= take_bit;
			if (take_bit) begin
				if (DW'(w_q) >= DW'(store_rdata)) begin
					w_q <= AW'(DW'(w_q) - DW'(store_rdata));
				end else begin
					w_q <= '0;
				end
			end
			if (k_q == '0) begin
				i_q <= '0;
			end else begin
				k_q <= k_q - KW'(1);
			end
		end
		if (load) begin
			on_first_q <= chosen_q[i_q];
			last_q <= is_last;
			if (chosen_q[i_q]) begin
				start_time_q <= first_q;
				first_q <= first_q + START_W'(store_rdata);
			end else begin
				start_time_q <= second_q;
				second_q <= second_q + START_W'(store_rdata);
			end
			i_q <= i_q + KW'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign start_time = start_time_q;
	assign on_first_machine = on_first_q;
	assign last_result = last_q;

endmodule

### hw/rtl/subset_sum_two_machine_split_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// cfg      in         cfg_valid/cfg_ready  capacity
// in       in         in_valid/in_stall    job_length, last_job
// out      out        out_valid/out_stall  start_time, on_first_machine, last_result
//
// Each held job runs a row sweep that visits every budget once,
// one budget a cycle through the row and decision memories.
// The final job adds a traceback through the read and execute states for each held job
// and an emission through the read and output states for each result, each step waiting on a registered memory read.
// Reset leaves no clearing pass: the first job of a set reads the row as zero.
// A stall on the output holds the result register and pauses the emission.
`include "subset_sum_two_machine_split_core_defines.svh"
module subset_sum_two_machine_split_core import ssts_pkg::*; #(
	parameter int MAX_JOBS = 64,
	parameter int MAX_CAPACITY = 4096,
	parameter int LENGTH_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CAP_W-1:0]       capacity,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [LENGTH_BITS-1:0] job_length,
	input  logic                   last_job,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [START_W-1:0]     start_time,
	output logic                   on_first_machine,
	output logic                   last_result
);

	localparam int AW = $clog2(MAX_CAPACITY);
	localparam int KW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNTW = $clog2(MAX_JOBS + 1);

	top_state_t state_q, state_d;

	logic [CAP_W-1:0] cap_q;
	logic [CNTW-1:0]  job_cnt_q;
	logic             last_q;

	logic accept;
	logic room;
	logic sweep_start;
	logic trace_start;
	logic sweep_done;
	logic trace_done;

	logic [AW-1:0]          sw_take_raddr;
	logic [AW-1:0]          tr_take_raddr;
	logic [AW-1:0]          take_raddr;
	logic [MAX_JOBS-1:0]    take_rdata;
	logic                   take_we;
	logic [AW-1:0]          take_waddr;
	logic [MAX_JOBS-1:0]    take_wdata;
	logic [KW-1:0]          store_raddr;
	logic [LENGTH_BITS-1:0] store_rdata;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TOP_IDLE: begin
				if (accept) begin
					if (room) begin
						state_d = TOP_SWEEP;
					end else if (last_job) begin
						state_d = TOP_LAUNCH;
					end
				end
			end
			TOP_SWEEP: if (sweep_done) state_d = last_q ? TOP_LAUNCH : TOP_IDLE;
			TOP_LAUNCH: state_d = TOP_TRACE;
			TOP_TRACE: if (trace_done) state_d = TOP_IDLE;
			default: state_d = TOP_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != TOP_IDLE;
		cfg_ready = 1'b1;
		accept = in_valid && !in_stall;
		room = job_cnt_q < CNTW'(MAX_JOBS);
		sweep_start = accept && room;
		trace_start = state_q == TOP_LAUNCH;
		take_raddr = (state_q == TOP_SWEEP) ? sw_take_raddr : tr_take_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_IDLE;
			cap_q <= CAP_RESET;
			job_cnt_q <= '0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity;
			end
			if (sweep_start) begin
				last_q <= last_job;
			end
			if (sweep_done) begin
				job_cnt_q <= job_cnt_q + CNTW'(1);
			end else if (trace_done) begin
				job_cnt_q <= '0;
			end
		end
	end

	ssts_ram #(.WIDTH(LENGTH_BITS), .DEPTH(MAX_JOBS)) u_store (
		.clk(clk), .we(sweep_start), .waddr(job_cnt_q[KW-1:0]), .wdata(job_length),
		.raddr(store_raddr), .rdata_q(store_rdata)
	);

	ssts_ram #(.WIDTH(MAX_JOBS), .DEPTH(MAX_CAPACITY)) u_take (
		.clk(clk), .we(take_we), .waddr(take_waddr), .wdata(take_wdata),
		.raddr(take_raddr), .rdata_q(take_rdata)
	);

	ssts_sweep #(
		.MAX_JOBS(MAX_JOBS), .MAX_CAPACITY(MAX_CAPACITY), .LENGTH_BITS(LENGTH_BITS)
	) u_sweep (
		.clk(clk), .arst_n(arst_n), .start(sweep_start), .first(job_cnt_q == '0),
		.len(job_length), .item(job_cnt_q[KW-1:0]),
		.take_raddr(sw_take_raddr), .take_rdata(take_rdata), .take_we(take_we),
		.take_waddr(take_waddr), .take_wdata(take_wdata), .done(sweep_done)
	);

	ssts_trace #(
		.MAX_JOBS(MAX_JOBS), .MAX_CAPACITY(MAX_CAPACITY), .LENGTH_BITS(LENGTH_BITS)
	) u_trace (
		.clk(clk), .arst_n(arst_n), .start(trace_start), .n(job_cnt_q), .cap(cap_q),
		.take_raddr(tr_take_raddr), .take_rdata(take_rdata),
		.store_raddr(store_raddr), .store_rdata(store_rdata),
		.out_stall(out_stall), .out_valid(out_valid), .start_time(start_time),
		.on_first_machine(on_first_machine), .last_result(last_result),
		.done(trace_done)
	);

	`SSTS_ASSERT(a_cnt_bound, clk, arst_n, job_cnt_q <= CNTW'(MAX_JOBS), "job count overflow")
	`SSTS_ASSERT(a_sweep_done, clk, arst_n, sweep_done |-> state_q == TOP_SWEEP, "stray sweep end")
	`SSTS_ASSERT(a_trace_done, clk, arst_n, trace_done |-> state_q == TOP_TRACE, "stray trace end")
	`SSTS_ASSERT_NEVER(a_take_wr, clk, arst_n, take_we && state_q == TOP_TRACE, "write in trace")

endmodule

### sim/ssts_split_checker.sv
`timescale 1ns / 1ps
module ssts_split_checker import ssts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CAP_W-1:0]   capacity,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [11:0]        job_length,
	input  logic               last_job,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [START_W-1:0] start_time,
	input  logic               on_first_machine,
	input  logic               last_result,
	output int                 errors,
	output int                 pending
);

	localparam int ROW_DEPTH = 4096;
	localparam int JOB_SLOTS = 64;
	localparam int PLAN_DEPTH = 128;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic               first;
		logic               last;
	} placement_t;

	logic [11:0] best_sum [ROW_DEPTH];
	logic [63:0] take_row [ROW_DEPTH];
	logic [11:0] held_len [JOB_SLOTS];
	int          held_count;
	logic [11:0] cap_reg;
	placement_t  plan_buf [PLAN_DEPTH];
	int          plan_wr;
	int          plan_rd;

	assign pending = plan_wr - plan_rd;

	task automatic sweep_job(input int slot, input logic [11:0] len);
		logic [12:0] cand;
		take_row[0][slot] = 1'b0;
		for (int j = ROW_DEPTH - 1; j >= 1; j--) begin
			take_row[j][slot] = 1'b0;
			if (j >= len) begin
				cand = best_sum[j - len] + len;
				if (cand > {1'b0, best_sum[j]}) begin
					best_sum[j] = cand[11:0];
					take_row[j][slot] = 1'b1;
				end
			end
		end
	endtask

	// Trace back from the budget, then place the jobs in load order.
	task automatic place_jobs();
		logic        chosen [JOB_SLOTS];
		int          budget;
		logic [17:0] first_sum;
		logic [17:0] second_sum;
		placement_t  p;
		budget = cap_reg;
		first_sum = '0;
		second_sum = '0;
		for (int k = held_count - 1; k >= 0; k--) begin
			chosen[k] = take_row[budget][k];
			if (chosen[k])
				budget = (budget >= held_len[k]) ? budget - held_len[k] : 0;
		end
		for (int i = 0; i < held_count; i++) begin
			p.first = chosen[i];
			p.last = (i == held_count - 1);
			if (chosen[i]) begin
				p.start = first_sum;
				first_sum += 18'(held_len[i]);
			end else begin
				p.start = second_sum;
				second_sum += 18'(held_len[i]);
			end
			plan_buf[plan_wr % PLAN_DEPTH] = p;
			plan_wr++;
		end
		for (int j = 0; j < ROW_DEPTH; j++)
			best_sum[j] = '0;
		held_count = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			for (int j = 0; j < ROW_DEPTH; j++) begin
				best_sum[j] = '0;
				take_row[j] = '0;
			end
			for (int i = 0; i < JOB_SLOTS; i++)
				held_len[i] = '0;
			held_count = 0;
			cap_reg = CAP_RESET;
			errors = 0;
			plan_wr = 0;
			plan_rd = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_reg = capacity;
			if (in_valid && !in_stall) begin
				if (held_count < JOB_SLOTS) begin
					held_len[held_count] = job_length;
					sweep_job(held_count, job_length);
					held_count++;
				end
				if (last_job)
					place_jobs();
			end
			if (out_valid && !out_stall) begin
				if (plan_wr == plan_rd) begin
					errors++;
					$display("%0t: unexpected item start=%0d first=%0b last=%0b",
						$time, start_time, on_first_machine, last_result);
				end else begin
					want = plan_buf[plan_rd % PLAN_DEPTH];
					plan_rd++;
					if (start_time !== want.start) begin
						errors++;
						$display("%0t: start_time expected %0d actual %0d",
							$time, want.start, start_time);
					end
					if (on_first_machine !== want.first) begin
						errors++;
						$display("%0t: on_first_machine expected %0b actual %0b",
							$time, want.first, on_first_machine);
					end
					if (last_result !== want.last) begin
						errors++;
						$display("%0t: last_result expected %0b actual %0b",
							$time, want.last, last_result);
					end
				end
			end
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top import ssts_pkg::*;;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CAP_W-1:0]   capacity;
	logic               in_valid;
	logic               in_stall;
	logic [11:0]        job_length;
	logic               last_job;
	logic               out_valid;
	logic               out_stall;
	logic [START_W-1:0] start_time;
	logic               on_first_machine;
	logic               last_result;
	int                 errors;
	int                 pending;
	bit                 calm;

	subset_sum_two_machine_split_core u_top (.*);

	ssts_split_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("subset_sum_two_machine_split_core: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver side: stalls of random length, none while calm.
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
	end

	task automatic send_job(input logic [11:0] len, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		job_length <= len;
		last_job <= fin;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Writes the capacity only once every result of the previous set has arrived.
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_valid <= 1'b1;
		capacity <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [11:0] rand_len();
		case ($urandom_range(0, 3))
			0: return 12'($urandom_range(0, 4095));
			1: return 12'($urandom_range(0, 15));
			default: return 12'($urandom_range(1, 600));
		endcase
	endfunction

	initial begin
		int n;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		capacity = '0;
		in_valid = 1'b0;
		job_length = '0;
		last_job = 1'b0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset capacity, extreme lengths and a zero-length job.
		send_job(12'd4095, 1'b0);
		send_job(12'd0, 1'b0);
		send_job(12'd2048, 1'b0);
		send_job(12'd2047, 1'b0);
		send_job(12'd1, 1'b1);
		// A set of one job.
		send_job(12'd4095, 1'b1);
		write_capacity(12'd0);
		send_job(12'd5, 1'b0);
		send_job(12'd0, 1'b0);
		send_job(12'd1, 1'b1);
		write_capacity(12'd1);
		send_job(12'd1, 1'b0);
		send_job(12'd1, 1'b0);
		send_job(12'd2, 1'b1);
		write_capacity(12'd2730);
		send_job(12'd1365, 1'b0);
		send_job(12'd2730, 1'b0);
		send_job(12'd1365, 1'b0);
		send_job(12'd0, 1'b1);

		// More than the job store holds: the surplus jobs are ignored.
		write_capacity(12'd4095);
		for (int i = 0; i < 66; i++)
			send_job(rand_len(), i == 65);

		for (int s = 0; s < 12; s++) begin
			calm = (s % 4 == 3);
			case ($urandom_range(0, 3))
				0: write_capacity(CAP_W'($urandom_range(0, 4095)));
				1: write_capacity(CAP_W'($urandom_range(0, 1200)));
				default: ;
			endcase
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				send_job(rand_len(), i == n - 1);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("subset_sum_two_machine_split_core: match");
		else
			$display("subset_sum_two_machine_split_core: mismatch");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ssts_pkg.sv
hw/rtl/ssts_ram.sv
hw/rtl/ssts_sweep.sv
hw/rtl/ssts_trace.sv
hw/rtl/subset_sum_two_machine_split_core.sv
sim/ssts_split_checker.sv
sim/tb_top.sv
